### design/pefe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pefe_pkg: shared types and constants of the pair escape frame encoder
// Byte commands passed from the classifier to the emitter, register codes
// and reset values of the configuration registers.
// ----------------------------------------------------------------------------
package pefe_pkg;

	// most bytes a single request can produce
	localparam int CMD_SLOTS   = 6;
	localparam int SLOT_W      = $clog2(CMD_SLOTS + 1);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 2'd2;

	localparam logic [7:0] ESCAPE_RST = 8'h1B;
	localparam logic [7:0] START_RST  = 8'h7B;
	localparam logic [7:0] END_RST    = 8'h7D;

	typedef struct packed {
		logic [7:0] escape_value;
		logic [7:0] start_value;
		logic [7:0] end_value;
	} cfg_t;

	// bytes to emit for one request, in order from slot 0
	typedef struct packed {
		logic [CMD_SLOTS-1:0][7:0] bytes;
		logic [SLOT_W-1:0]         count;
		logic                      done;   // last byte closes the frame
	} cmd_t;

	// queue head as seen by the emitter
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage
`default_nettype wire

### design/pefe_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pefe_in_if: payload byte channel
// Valid/ready channel carrying one frame payload byte and its last flag.
// ----------------------------------------------------------------------------
interface pefe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_last;

	modport source (output valid, output data_byte, output frame_last, input ready);
	modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface
`default_nettype wire

### design/pefe_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pefe_out_if: encoded byte channel
// Valid/ready channel carrying one byte of the framed stream and its flags.
// ----------------------------------------------------------------------------
interface pefe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_done;

	modport source (output valid, output out_byte, output run_last, output frame_done,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input frame_done,
		output ready);
endinterface
`default_nettype wire

### design/pair_escape_frame_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pair_escape_frame_encoder: byte-stuffing framer with pair escaping
// Wraps payload bytes in doubled start/end markers and escapes equal pairs
// of marker bytes; a classifier, a command queue and a byte emitter.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Payload
//  in_ch     in   valid/ready    data_byte[7:0], frame_last
//  out_ch    out  valid/ready    out_byte[7:0], run_last, frame_done
//  cfg_*     in   cfg_we         cfg_idx[1:0], cfg_wdata[7:0]
//
//  One request is accepted per cycle while the two-entry command queue has room.
//  The emitter sends one byte per cycle while the output is not stalled; a request
//  yields 0 to 6 bytes, which pass through the queue and the output register.
//  arst_n clears frame state, the queue and the output register and loads the
//  register defaults (escape 0x1B, start 0x7B, end 0x7D).
//  Output stalls back up into the queue and then drop in_ch.ready.
// ----------------------------------------------------------------------------
module pair_escape_frame_encoder
	import pefe_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pefe_in_if.sink                    in_ch,
	pefe_out_if.source                 out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t    cfg_q;
	logic    push;
	logic    q_full;
	logic    pop;
	cmd_t    cmd;
	q_head_t q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_value <= ESCAPE_RST;
			cfg_q.start_value  <= START_RST;
			cfg_q.end_value    <= END_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ESCAPE: cfg_q.escape_value <= cfg_wdata;
				REG_START:  cfg_q.start_value  <= cfg_wdata;
				REG_END:    cfg_q.end_value    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	pefe_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg_q),
		.q_full (q_full),
		.push   (push),
		.cmd    (cmd)
	);

	pefe_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (cmd),
		.full   (q_full),
		.head   (q_head),
		.pop    (pop)
	);

	pefe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (pop),
		.out_ch (out_ch)
	);

	// no command is written into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("command pushed into full queue");

	// queued commands always carry at least one byte
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_head.valid |-> (q_head.cmd.count != '0))
		else $error("empty command at queue head");

	// frame end is always the last byte of its request
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.frame_done) |-> out_ch.run_last)
		else $error("frame_done without run_last");

	// popping only happens with a command present
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_head.valid)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

### design/pefe_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pefe_front: request classifier
// Accepts payload bytes, tracks frame and held-byte state and turns each
// request into a command of up to six bytes for the emitter.
// ----------------------------------------------------------------------------
module pefe_front
	import pefe_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	pefe_in_if.sink    in_ch,
	input  wire cfg_t  cfg,
	input  wire logic  q_full,
	output logic       push,
	output cmd_t       cmd
);

	logic       in_frame_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;

	logic       accept;
	logic       held_ok;
	logic       pair;
	logic [7:0] b;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign b           = in_ch.data_byte;

	// held byte only counts inside an open frame
	assign held_ok = held_valid_q && in_frame_q;
	assign pair    = held_ok && (held_byte_q == b)
		&& ((b == cfg.start_value) || (b == cfg.end_value));

	// build the byte list in emit order
	always_comb begin
		logic [SLOT_W-1:0] slot;
		slot = '0;
		cmd  = '0;
		if (!in_frame_q) begin
			cmd.bytes[slot] = cfg.start_value;
			slot = slot + 1'b1;
			cmd.bytes[slot] = cfg.start_value;
			slot = slot + 1'b1;
		end
		if (pair) begin
			cmd.bytes[slot] = cfg.escape_value;
			slot = slot + 1'b1;
			cmd.bytes[slot] = cfg.escape_value;
			slot = slot + 1'b1;
			cmd.bytes[slot] = held_byte_q;
			slot = slot + 1'b1;
			cmd.bytes[slot] = b;
			slot = slot + 1'b1;
		end else if (held_ok) begin
			cmd.bytes[slot] = held_byte_q;
			slot = slot + 1'b1;
		end
		if (in_ch.frame_last) begin
			// flush the new byte unless it was just paired
			if (!pair) begin
				cmd.bytes[slot] = b;
				slot = slot + 1'b1;
			end
			cmd.bytes[slot] = cfg.end_value;
			slot = slot + 1'b1;
			cmd.bytes[slot] = cfg.end_value;
			slot = slot + 1'b1;
		end
		cmd.count = slot;
		cmd.done  = in_ch.frame_last;
	end

	// a request that emits nothing leaves the queue alone
	assign push = accept && (cmd.count != '0);

	// frame and held-byte state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			held_valid_q <= 1'b0;
			held_byte_q  <= '0;
		end else if (accept) begin
			if (in_ch.frame_last) begin
				in_frame_q   <= 1'b0;
				held_valid_q <= 1'b0;
			end else begin
				in_frame_q   <= 1'b1;
				held_valid_q <= !pair;
			end
			if (!pair) begin
				held_byte_q <= b;
			end
		end
	end

endmodule
`default_nettype wire

### design/pefe_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pefe_queue: command queue
// Small FIFO of byte commands between the classifier and the emitter so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module pefe_queue
	import pefe_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire cmd_t  wr_cmd,
	output logic       full,
	output q_head_t    head,
	input  wire logic  pop
);

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### design/pefe_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pefe_back: byte emitter
// Walks the head command into the output register one byte per cycle while the
// output is not stalled, and pops the command after its final byte.
// ----------------------------------------------------------------------------
module pefe_back
	import pefe_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_head_t head,
	output logic         pop,
	pefe_out_if.source   out_ch
);

	logic [SLOT_W-1:0] idx_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              run_last_q;
	logic              frame_done_q;

	logic advance;
	logic at_end;

	assign advance = !out_valid_q || out_ch.ready;
	assign at_end  = (idx_q == (head.cmd.count - 1'b1));
	assign pop     = advance && head.valid && at_end;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_byte   = out_byte_q;
	assign out_ch.run_last   = run_last_q;
	assign out_ch.frame_done = frame_done_q;

	// output register and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
			out_byte_q   <= '0;
			run_last_q   <= 1'b0;
			frame_done_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head.valid;
			if (head.valid) begin
				out_byte_q   <= head.cmd.bytes[idx_q[SLOT_W-1:0]];
				run_last_q   <= at_end;
				frame_done_q <= at_end && head.cmd.done;
				idx_q        <= at_end ? '0 : idx_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### verif/pair_escape_frame_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pair_escape_frame_encoder_test: self-checking bench for the framer
// Sends payload bytes under random idling on both channels and one long
// output hold-off. A directed table comes first, then random frames under
// several marker settings. Every encoded byte and its flags are checked against
// the typed bytes of a directed row or else a local encoder model.
// ----------------------------------------------------------------------------
module pair_escape_frame_encoder_test;
	import pefe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int N_DIR       = 15;
	localparam int N_PHASES    = 5;
	localparam int PHASE_ITEMS = 43;
	localparam int HOLD_AT     = 70;   // requests accepted before the long hold-off
	localparam int HOLD_CYCLES = 80;

	// one payload request; n_typed < 0 means the local encoder supplies the bytes
	typedef struct packed {
		logic [7:0]      data;
		logic            last;
		int              n_typed;
		logic [0:5][7:0] typed;
	} stim_row_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
	} enc_byte_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	pefe_in_if  req_ch();
	pefe_out_if enc_ch();

	pair_escape_frame_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (req_ch),
		.out_ch    (enc_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// encoder model state and register copy
	logic       fr_open;
	logic       held_ok;
	logic [7:0] held_b;
	logic [7:0] reg_esc;
	logic [7:0] reg_start;
	logic [7:0] reg_end;

	enc_byte_t expected_stream[$];
	int        mismatch_cnt = 0;
	int        sent_cnt = 0;
	logic      quiet = 1'b0;
	logic      hold_active = 1'b0;
	logic      hold_done = 1'b0;

	// directed requests, default markers after reset
	stim_row_t dir_rows [N_DIR] = '{
		'{8'h41, 1'b0, 2, {8'h7B, 8'h7B, 32'h0}},                    // start marker
		'{8'h41, 1'b1, 4, {8'h41, 8'h41, 8'h7D, 8'h7D, 16'h0}},      // plain pair, close
		'{8'h7B, 1'b0, 2, {8'h7B, 8'h7B, 32'h0}},
		'{8'h7B, 1'b0, 4, {8'h1B, 8'h1B, 8'h7B, 8'h7B, 16'h0}},      // escaped start pair
		'{8'h7B, 1'b0, 0, 48'h0},                                    // nothing to emit
		'{8'h7B, 1'b1, 6, {8'h1B, 8'h1B, 8'h7B, 8'h7B, 8'h7D, 8'h7D}},
		'{8'h7D, 1'b1, 5, {8'h7B, 8'h7B, 8'h7D, 8'h7D, 8'h7D, 8'h0}}, // one-byte frame
		'{8'h00, 1'b0, -1, 48'h0},
		'{8'hFF, 1'b0, -1, 48'h0},
		'{8'hFF, 1'b0, -1, 48'h0},
		'{8'h1B, 1'b0, -1, 48'h0},                                   // escape in payload
		'{8'h1B, 1'b0, -1, 48'h0},
		'{8'h7D, 1'b0, -1, 48'h0},
		'{8'h7D, 1'b0, -1, 48'h0},                                   // escaped end pair
		'{8'h7D, 1'b1, -1, 48'h0}                                    // unpaired last byte
	};

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// encode one request: fills the bytes it yields, returns how many
	function automatic int frame_encode(input logic [7:0] b, input logic lst,
			output logic [0:5][7:0] ob);
		int n = 0;
		ob = '0;
		if (!fr_open) begin
			ob[n] = reg_start; n++;
			ob[n] = reg_start; n++;
			fr_open = 1'b1;
			held_ok = 1'b0;
		end
		if (held_ok && held_b == b && (b == reg_start || b == reg_end)) begin
			ob[n] = reg_esc; n++;
			ob[n] = reg_esc; n++;
			ob[n] = held_b;  n++;
			ob[n] = b;       n++;
			held_ok = 1'b0;
		end else begin
			if (held_ok) begin
				ob[n] = held_b; n++;
			end
			held_b  = b;
			held_ok = 1'b1;
		end
		if (lst) begin
			if (held_ok) begin
				ob[n] = held_b; n++;
			end
			ob[n] = reg_end; n++;
			ob[n] = reg_end; n++;
			held_ok = 1'b0;
			fr_open = 1'b0;
		end
		return n;
	endfunction

	// queue the bytes of one accepted request, flags on the final one
	function automatic void accept_req(input stim_row_t r);
		logic [0:5][7:0] ob;
		int n;
		n = frame_encode(r.data, r.last, ob);
		if (r.n_typed >= 0) begin
			n  = r.n_typed;
			ob = r.typed;
		end
		for (int i = 0; i < n; i++)
			expected_stream.push_back('{ob[i], i == n - 1, (i == n - 1) && r.last});
		sent_cnt++;
	endfunction

	// offer one request, called and returning at a falling edge
	task automatic offer(input stim_row_t r);
		if (!quiet && !hold_active && $urandom_range(0, 5) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.data_byte  <= r.data;
		req_ch.frame_last <= r.last;
		do @(posedge clk); while (!req_ch.ready);
		accept_req(r);
		@(negedge clk);
	endtask

	// stop sending and wait until the encoded stream has fully drained
	task automatic drain;
		req_ch.valid <= 1'b0;
		while (expected_stream.size() != 0)
			@(negedge clk);
		// a request with no bytes may still be in flight
		repeat (8) @(negedge clk);
	endtask

	// write all registers on consecutive cycles, the unused index included
	task automatic load_regs(input logic [7:0] e, input logic [7:0] s, input logic [7:0] t);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_UNUSED;
		cfg_wdata <= 8'($urandom);
		@(negedge clk);
		cfg_idx   <= REG_ESCAPE;
		cfg_wdata <= e;
		@(negedge clk);
		cfg_idx   <= REG_START;
		cfg_wdata <= s;
		@(negedge clk);
		cfg_idx   <= REG_END;
		cfg_wdata <= t;
		@(negedge clk);
		cfg_we    <= 1'b0;
		reg_esc   = e;
		reg_start = s;
		reg_end   = t;
	endtask

	// output side: random stalls, one long hold-off, steady ready at the end
	initial begin : drain_ctl
		int burst;
		enc_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && sent_cnt >= HOLD_AT) begin
				hold_done   = 1'b1;
				hold_active = 1'b1;
				enc_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_active = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 17);
				enc_ch.ready <= 1'b0;
				repeat (burst - 1) @(negedge clk);
			end else begin
				enc_ch.ready <= 1'b1;
			end
		end
	end

	// check each encoded byte against the oldest expectation
	always @(posedge clk) begin : enc_monitor
		enc_byte_t got;
		enc_byte_t want;
		if (arst_n && enc_ch.valid && enc_ch.ready) begin
			got = '{enc_ch.out_byte, enc_ch.run_last, enc_ch.frame_done};
			if (expected_stream.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected byte: expected none, got %h run_last %b frame_done %b",
					$time, got.out_byte, got.run_last, got.frame_done);
			end else begin
				want = expected_stream.pop_front();
				if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
						got.frame_done !== want.frame_done) begin
					mismatch_cnt++;
					$display("%0t: expected %h/%b/%b got %h/%b/%b (out_byte/run_last/frame_done)",
						$time, want.out_byte, want.run_last, want.frame_done,
						got.out_byte, got.run_last, got.frame_done);
				end
			end
		end
	end

	// stimulus
	initial begin : stim
		stim_row_t  r;
		logic [7:0] e, s, t;
		int         sel;
		req_ch.valid      = 1'b0;
		req_ch.data_byte  = 8'h00;
		req_ch.frame_last = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = REG_ESCAPE;
		cfg_wdata = 8'h00;
		arst_n    = 1'b0;
		fr_open   = 1'b0;
		held_ok   = 1'b0;
		held_b    = 8'h00;
		reg_esc   = ESCAPE_RST;
		reg_start = START_RST;
		reg_end   = END_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i]);
		drain();

		// random frames under several marker settings, the last one without idling
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin e = 8'h00; s = 8'hFF; t = 8'h00; end
				1: begin e = 8'hFF; s = 8'h00; t = 8'hFF; end
				2: begin e = 8'h5A; s = 8'hA5; t = 8'hA5; end   // start equals end
				3: begin e = 8'($urandom); s = 8'($urandom); t = 8'($urandom); end
				default: begin
					e = ESCAPE_RST; s = START_RST; t = END_RST;
					quiet = 1'b1;
				end
			endcase
			load_regs(e, s, t);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// favor marker values so that pairs and runs show up often
				sel = $urandom_range(0, 9);
				if (sel < 4)
					r.data = reg_start;
				else if (sel < 6)
					r.data = reg_end;
				else if (sel == 6)
					r.data = reg_esc;
				else
					r.data = 8'($urandom);
				r.last    = ($urandom_range(0, 6) == 0);
				r.n_typed = -1;
				r.typed   = '0;
				offer(r);
			end
			drain();
		end

		repeat (10) @(negedge clk);
		if (mismatch_cnt == 0 && expected_stream.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit
	initial begin : watchdog
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

### filelist.f
design/pefe_pkg.sv
design/pefe_in_if.sv
design/pefe_out_if.sv
design/pefe_front.sv
design/pefe_queue.sv
design/pefe_back.sv
design/pair_escape_frame_encoder.sv
verif/pair_escape_frame_encoder_test.sv
